// File: sv/ptxh_pkg.sv
// Shared types, constants and text tables for the plain text to HTML stream block.
package ptxh_pkg;

   localparam int TAB_WIDTH_DEF = 8;
   localparam int TAB_WIDTH_MAX = 16;
   localparam int MAX_RESULTS   = 17;
   localparam int SLOTS         = 3;
   localparam int SLOT_W        = 2;
   localparam int POS_W         = 5;
   localparam int CNT_W         = 5;
   localparam int NBSP_CNT_W    = 5;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [15:0] CODE_TAB  = 16'h0009;
   localparam logic [15:0] CODE_LF   = 16'h000A;
   localparam logic [15:0] CODE_LT   = 16'h003C;
   localparam logic [15:0] CODE_GT   = 16'h003E;
   localparam logic [15:0] CODE_AMP  = 16'h0026;
   localparam logic [15:0] CODE_NBSP = 16'h00A0;

   typedef enum logic [3:0] {
      SEG_NONE,
      SEG_P_OPEN,
      SEG_BR,
      SEG_P_CLOSE_NL,
      SEG_P_CLOSE,
      SEG_LT,
      SEG_GT,
      SEG_AMP,
      SEG_CHAR,
      SEG_NBSP
   } seg_kind_type;

   typedef struct packed {
      seg_kind_type [SLOTS-1:0]  seg;
      logic [15:0]               code;
      logic [NBSP_CNT_W-1:0]     nbsp_cnt;
      logic                      last;
   } cmd_type;

   function automatic logic is_space(input logic [15:0] c);
      return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
             c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
             c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
             c == 16'h3000;
   endfunction

   function automatic logic [POS_W-1:0] seg_len(input seg_kind_type kind,
                                                 input logic [NBSP_CNT_W-1:0] nbsp_cnt);
      logic [POS_W-1:0] len;
      case (kind)
         SEG_P_OPEN:     len = POS_W'(3);
         SEG_BR:         len = POS_W'(5);
         SEG_P_CLOSE_NL: len = POS_W'(5);
         SEG_P_CLOSE:    len = POS_W'(4);
         SEG_LT:         len = POS_W'(4);
         SEG_GT:         len = POS_W'(4);
         SEG_AMP:        len = POS_W'(5);
         SEG_NBSP:       len = POS_W'(nbsp_cnt);
         default:        len = POS_W'(1);
      endcase
      return len;
   endfunction

   function automatic logic [15:0] seg_char(input seg_kind_type kind,
                                            input logic [POS_W-1:0] pos,
                                            input logic [15:0] code);
      logic [7:0] ch;
      ch = 8'h00;
      case (kind)
         SEG_P_OPEN: begin
            case (pos)
               POS_W'(0): ch = 8'h3C;
               POS_W'(1): ch = 8'h70;
               default:   ch = 8'h3E;
            endcase
         end
         SEG_BR: begin
            case (pos)
               POS_W'(0): ch = 8'h3C;
               POS_W'(1): ch = 8'h62;
               POS_W'(2): ch = 8'h72;
               POS_W'(3): ch = 8'h3E;
               default:   ch = 8'h0A;
            endcase
         end
         SEG_P_CLOSE_NL, SEG_P_CLOSE: begin
            case (pos)
               POS_W'(0): ch = 8'h3C;
               POS_W'(1): ch = 8'h2F;
               POS_W'(2): ch = 8'h70;
               POS_W'(3): ch = 8'h3E;
               default:   ch = 8'h0A;
            endcase
         end
         SEG_LT: begin
            case (pos)
               POS_W'(0): ch = 8'h26;
               POS_W'(1): ch = 8'h6C;
               POS_W'(2): ch = 8'h74;
               default:   ch = 8'h3B;
            endcase
         end
         SEG_GT: begin
            case (pos)
               POS_W'(0): ch = 8'h26;
               POS_W'(1): ch = 8'h67;
               POS_W'(2): ch = 8'h74;
               default:   ch = 8'h3B;
            endcase
         end
         SEG_AMP: begin
            case (pos)
               POS_W'(0): ch = 8'h26;
               POS_W'(1): ch = 8'h61;
               POS_W'(2): ch = 8'h6D;
               POS_W'(3): ch = 8'h70;
               default:   ch = 8'h3B;
            endcase
         end
         default: ch = 8'h00;
      endcase
      if (kind == SEG_CHAR) begin
         return code;
      end else if (kind == SEG_NBSP) begin
         return CODE_NBSP;
      end
      return {8'h00, ch};
   endfunction

endpackage

// File: sv/ptxh_front.sv
// Front end: accepts input words, tracks line state and turns each word into a segment command.
module ptxh_front #(
   parameter int TAB_WIDTH = ptxh_pkg::TAB_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [15:0]       req_char_code,
   input  logic              req_last_char,
   input  logic              csr_valid,
   input  logic              csr_pre_mode,
   input  logic              q_full,
   output logic              req_ready,
   output logic              q_push,
   output ptxh_pkg::cmd_type q_push_data
);

   localparam int COL_W = $clog2(TAB_WIDTH);

   logic             pre_mode_ff, pre_mode_in;
   logic             in_msg_ff, in_msg_in;
   logic [1:0]       pend_ff, pend_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             nonempty_ff, nonempty_in;
   logic             at_start_ff, at_start_in;

   ptxh_pkg::seg_kind_type cand [5];
   ptxh_pkg::cmd_type      cmd;
   logic [2:0]             n;
   logic                   keep;
   logic                   accept;
   logic [COL_W-1:0]       col_inc;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign col_inc   = (col_ff == COL_W'(TAB_WIDTH - 1)) ? '0 : col_ff + 1'b1;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         cand[i] = ptxh_pkg::SEG_NONE;
      end
      pend_in     = pend_ff;
      col_in      = col_ff;
      nonempty_in = nonempty_ff;
      at_start_in = at_start_ff;
      in_msg_in   = 1'b1;
      keep        = 1'b0;
      cmd.code     = req_char_code;
      cmd.nbsp_cnt = ptxh_pkg::NBSP_CNT_W'(1);
      cmd.last     = req_last_char;

      if (!in_msg_ff) begin
         cand[0] = ptxh_pkg::SEG_P_OPEN;
      end

      if (req_char_code == ptxh_pkg::CODE_LF) begin
         case (pend_ff)
            2'd0:    pend_in = 2'd1;
            2'd1: begin
               cand[1] = ptxh_pkg::SEG_P_CLOSE_NL;
               pend_in = 2'd2;
            end
            default: cand[1] = ptxh_pkg::SEG_BR;
         endcase
         col_in      = '0;
         nonempty_in = 1'b0;
         at_start_in = 1'b1;
      end else begin
         // close the held newline run
         case (pend_ff)
            2'd1:    cand[1] = ptxh_pkg::SEG_BR;
            2'd2:    cand[1] = ptxh_pkg::SEG_P_OPEN;
            default: cand[1] = ptxh_pkg::SEG_NONE;
         endcase
         pend_in = 2'd0;
         col_in  = col_inc;
         if (pre_mode_ff && req_char_code == ptxh_pkg::CODE_TAB) begin
            cand[2]      = ptxh_pkg::SEG_NBSP;
            cmd.nbsp_cnt = ptxh_pkg::NBSP_CNT_W'(TAB_WIDTH) -
                           ptxh_pkg::NBSP_CNT_W'(col_ff);
            col_in       = COL_W'(1);
            keep         = at_start_ff;
         end else if ((at_start_ff || pre_mode_ff) && ptxh_pkg::is_space(req_char_code)) begin
            cand[2] = ptxh_pkg::SEG_NBSP;
            keep    = at_start_ff;
         end else if (req_char_code == ptxh_pkg::CODE_LT) begin
            cand[2] = ptxh_pkg::SEG_LT;
         end else if (req_char_code == ptxh_pkg::CODE_GT) begin
            cand[2] = ptxh_pkg::SEG_GT;
         end else if (req_char_code == ptxh_pkg::CODE_AMP) begin
            cand[2] = ptxh_pkg::SEG_AMP;
         end else begin
            cand[2] = ptxh_pkg::SEG_CHAR;
         end
         nonempty_in = 1'b1;
         at_start_in = keep;
      end

      if (req_last_char) begin
         case (pend_in)
            2'd1:    cand[3] = ptxh_pkg::SEG_BR;
            2'd2:    cand[3] = ptxh_pkg::SEG_P_OPEN;
            default: cand[3] = ptxh_pkg::SEG_NONE;
         endcase
         if (nonempty_in) begin
            cand[4] = ptxh_pkg::SEG_P_CLOSE;
         end
         in_msg_in   = 1'b0;
         pend_in     = 2'd0;
         col_in      = '0;
         nonempty_in = 1'b0;
         at_start_in = 1'b1;
      end

      // pack the present segments to the low slots
      for (int s = 0; s < ptxh_pkg::SLOTS; s++) begin
         cmd.seg[s] = ptxh_pkg::SEG_NONE;
      end
      n = 3'd0;
      for (int i = 0; i < 5; i++) begin
         if (cand[i] != ptxh_pkg::SEG_NONE && n < 3'(ptxh_pkg::SLOTS)) begin
            cmd.seg[n[ptxh_pkg::SLOT_W-1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
   end

   // drop commands that emit nothing
   assign q_push      = accept && (cmd.seg[0] != ptxh_pkg::SEG_NONE);
   assign q_push_data = cmd;
   assign pre_mode_in = csr_valid ? csr_pre_mode : pre_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_mode_ff <= 1'b0;
         in_msg_ff   <= 1'b0;
         pend_ff     <= 2'd0;
         col_ff      <= '0;
         nonempty_ff <= 1'b0;
         at_start_ff <= 1'b1;
      end else begin
         pre_mode_ff <= pre_mode_in;
         if (accept) begin
            in_msg_ff   <= in_msg_in;
            pend_ff     <= pend_in;
            col_ff      <= col_in;
            nonempty_ff <= nonempty_in;
            at_start_ff <= at_start_in;
         end
      end
   end

endmodule

// File: sv/ptxh_queue.sv
// Command queue between the front and back ends.
module ptxh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptxh_pkg::cmd_type push_data,
   input  logic              pop,
   output ptxh_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = $clog2(ptxh_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ptxh_pkg::QUEUE_DEPTH + 1);

   ptxh_pkg::cmd_type store_ff [ptxh_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == CNT_W'(ptxh_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/ptxh_back.sv
// Back end: expands segment commands into output words, one word per cycle while rsp_ready is high.
module ptxh_back (
   input  logic              clock,
   input  logic              reset,
   input  ptxh_pkg::cmd_type head,
   input  logic              q_empty,
   input  logic              rsp_ready,
   output logic              q_pop,
   output logic              rsp_valid,
   output logic [15:0]       rsp_out_code,
   output logic              rsp_out_last
);

   logic [ptxh_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [ptxh_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [ptxh_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [15:0]                 rsp_code_ff, rsp_code_in;
   logic                        rsp_last_ff, rsp_last_in;

   ptxh_pkg::seg_kind_type kind, next_kind;
   logic [ptxh_pkg::POS_W-1:0] len;
   logic                       seg_end, cmd_end, load;

   always_comb begin
      kind = head.seg[slot_ff];
      case (slot_ff)
         ptxh_pkg::SLOT_W'(0): next_kind = head.seg[1];
         ptxh_pkg::SLOT_W'(1): next_kind = head.seg[2];
         default:              next_kind = ptxh_pkg::SEG_NONE;
      endcase
      len     = ptxh_pkg::seg_len(kind, head.nbsp_cnt);
      seg_end = (pos_ff == len - 1'b1);
      // stop at the end of the command or at the word limit
      cmd_end = (seg_end && next_kind == ptxh_pkg::SEG_NONE) ||
                (cnt_ff == ptxh_pkg::CNT_W'(ptxh_pkg::MAX_RESULTS - 1));
      load    = !q_empty && (!rsp_valid_ff || rsp_ready);

      slot_in      = slot_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = ptxh_pkg::seg_char(kind, pos_ff, head.code);
         rsp_last_in  = head.last && cmd_end;
         if (cmd_end) begin
            slot_in = '0;
            pos_in  = '0;
            cnt_in  = '0;
            q_pop   = 1'b1;
         end else if (seg_end) begin
            slot_in = slot_ff + 1'b1;
            pos_in  = '0;
            cnt_in  = cnt_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_code = rsp_code_ff;
   assign rsp_out_last = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// File: sv/plain_text_to_html_stream.sv
// Top level of the plain text to HTML stream converter.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_char_code[15:0], req_last_char
//   rsp       out        rsp_valid/rsp_ready  rsp_out_code[15:0], rsp_out_last
//   csr       in         csr_valid/csr_ready  csr_pre_mode
//
// The front takes one input word per cycle while the 4-entry command queue has room.
// The back sends one output word per cycle while rsp_ready is high; an input word
// yields 1 to 17 output words, and a held newline yields none.
// Reset is synchronous and clears the line state, the queue and pre_mode.
// A stalled rsp side fills the queue and then drops req_ready; csr is always ready.
module plain_text_to_html_stream #(
   parameter int TAB_WIDTH = ptxh_pkg::TAB_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_out_code,
   output logic        rsp_out_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_pre_mode
);

   ptxh_pkg::cmd_type q_push_data, q_head;
   logic              q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   ptxh_front #(
      .TAB_WIDTH (TAB_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .csr_valid     (csr_valid),
      .csr_pre_mode  (csr_pre_mode),
      .q_full        (q_full),
      .req_ready     (req_ready),
      .q_push        (q_push),
      .q_push_data   (q_push_data)
   );

   ptxh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   ptxh_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .q_empty      (q_empty),
      .rsp_ready    (rsp_ready),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_out_code (rsp_out_code),
      .rsp_out_last (rsp_out_last)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

   a_push_leaves_entry: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !q_empty)
      else $error("queue empty after push");

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("command retired without an output word");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !q_pop)
      else $error("pop from empty queue");

endmodule
